[hdl/iirdf1_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// iirdf1_pkg
// Shared widths, beat types and constants of the direct form I IIR filter.
// ============================================================================
package iirdf1_pkg;

    localparam int SAMP_W     = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMP_W + COEF_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

    localparam int FF_TAPS    = 4;
    localparam int FB_TAPS    = 4;
    localparam int NUM_CELLS  = 3;

    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int PADDR_W    = REG_IDX_W + 2;
    localparam int PDATA_W    = 32;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic signed [SAMP_W-1:0] SAMP_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
    localparam logic signed [SAMP_W-1:0] SAMP_MIN = {1'b1, {(SAMP_W-1){1'b0}}};

    typedef struct packed {
        logic                     op;
        logic signed [SAMP_W-1:0] sample;
    } smp_t;

    typedef struct packed {
        logic signed [SAMP_W-1:0] filtered;
        logic                     clipped;
    } flt_t;

endpackage

[hdl/iir_direct_form_one_filter_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// iir_direct_form_one_filter_top
// Direct form I IIR filter, Q1.15 samples, Q2.14 coefficients, APB config.
// ============================================================================
// Takes one sample beat per clock while the result side is ready and shows
// its result from an output register in the next cycle. The cycle is set
// by the feedback path: y[n-1] goes through the tap multipliers, the sum
// along the row of delay cells and the round/saturate stage before it is
// stored again. fb_coef_0 and fb_coef_1 both weigh y[n-1]. A clear beat
// zeroes both histories and returns no result. The user must write the
// coefficients over APB while the filter is idle; it is not enforced.
module iir_direct_form_one_filter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                smp_valid,
    output logic                                smp_ready,
    input  iirdf1_pkg::smp_t                    smp,
    output logic                                flt_valid,
    input  logic                                flt_ready,
    output iirdf1_pkg::flt_t                    flt,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iirdf1_pkg::PADDR_W-1:0]      paddr,
    input  logic [iirdf1_pkg::PDATA_W-1:0]      pwdata,
    output logic [iirdf1_pkg::PDATA_W-1:0]      prdata,
    output logic                                pready
);
    import iirdf1_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
    logic [REG_IDX_W-1:0]     reg_idx;

    logic smp_fire;
    logic filt_fire;
    logic clear_fire;

    logic signed [SAMP_W-1:0] x_chain   [NUM_CELLS+1];
    logic signed [SAMP_W-1:0] y_chain   [NUM_CELLS+1];
    logic signed [ACC_W-1:0]  acc_chain [NUM_CELLS+1];
    logic signed [COEF_W-1:0] ff_tap    [NUM_CELLS];
    logic signed [COEF_W-1:0] fb_tap    [NUM_CELLS];

    logic signed [PROD_W-1:0] head_ff;
    logic signed [PROD_W-1:0] head_fb;
    flt_t                     flt_calc;

    flt_t flt_reg;
    flt_t flt_next;
    logic flt_valid_reg;
    logic flt_valid_next;

    // config port
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign pready  = 1'b1;
    assign prdata  = PDATA_W'(coef_reg[reg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            coef_reg[reg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    // handshake
    assign smp_ready  = !flt_valid_reg || flt_ready;
    assign smp_fire   = smp_valid && smp_ready;
    assign filt_fire  = smp_fire && (smp.op == OP_FILTER);
    assign clear_fire = smp_fire && (smp.op == OP_CLEAR);

    // head taps: x[n] and the extra y[n-1] weight
    always_comb
    begin
        if (FF_TAPS > 0)
        begin
            head_ff = PROD_W'(smp.sample) * PROD_W'(coef_reg[0]);
        end
        else
        begin
            head_ff = PROD_W'(smp.sample) <<< FRAC_SHIFT;
        end
        if (FB_TAPS > 0)
        begin
            head_fb = PROD_W'(y_chain[1]) * PROD_W'(coef_reg[FF_TAPS > 0 ? 4 : 4]);
        end
        else
        begin
            head_fb = '0;
        end
    end

    assign x_chain[0]   = smp.sample;
    assign y_chain[0]   = flt_calc.filtered;
    assign acc_chain[0] = ACC_W'(head_ff) + ACC_W'(head_fb);

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        assign ff_tap[k] = (k + 1 < FF_TAPS) ? coef_reg[k+1] : '0;
        assign fb_tap[k] = (k + 1 < FB_TAPS) ? coef_reg[NUM_REGS/2+k+1] : '0;

        iirdf1_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (filt_fire),
            .clear   (clear_fire),
            .x_in    (x_chain[k]),
            .y_in    (y_chain[k]),
            .ff_coef (ff_tap[k]),
            .fb_coef (fb_tap[k]),
            .acc_in  (acc_chain[k]),
            .x_out   (x_chain[k+1]),
            .y_out   (y_chain[k+1]),
            .acc_out (acc_chain[k+1])
        );
    end

    iirdf1_rndsat u_rndsat (
        .acc (acc_chain[NUM_CELLS]),
        .flt (flt_calc)
    );

    // output register
    always_comb
    begin
        flt_next       = flt_reg;
        flt_valid_next = flt_valid_reg && !flt_ready;
        if (filt_fire)
        begin
            flt_next       = flt_calc;
            flt_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flt_valid_reg <= 1'b0;
        end
        else
        begin
            flt_valid_reg <= flt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flt_reg <= flt_next;
    end

    assign flt_valid = flt_valid_reg;
    assign flt       = flt_reg;

`ifndef SYNTH
    a_clear_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        clear_fire |=> !flt_valid)
        else $error("clear produced a result beat");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        clear_fire |=> (y_chain[1] == '0) && (x_chain[NUM_CELLS] == '0)
                       && (y_chain[NUM_CELLS] == '0))
        else $error("history not cleared");

    a_filter_beat: assert property (@(posedge clk) disable iff (!rst_n)
        filt_fire |=> flt_valid && (y_chain[1] == flt.filtered))
        else $error("filter beat lost or history out of step");

    a_clip_range: assert property (@(posedge clk) disable iff (!rst_n)
        flt_valid && flt.clipped |-> (flt.filtered == SAMP_MAX)
                                     || (flt.filtered == SAMP_MIN))
        else $error("clipped result not at a range end");
`endif

endmodule

[hdl/iirdf1_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// iirdf1_cell
// One delay cell: holds x[n-k] and y[n-k], adds both tap products to the
// running sum and hands its history values to the next cell.
// ============================================================================
module iirdf1_cell (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    clear,
    input  logic signed [iirdf1_pkg::SAMP_W-1:0]    x_in,
    input  logic signed [iirdf1_pkg::SAMP_W-1:0]    y_in,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]    ff_coef,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]    fb_coef,
    input  logic signed [iirdf1_pkg::ACC_W-1:0]     acc_in,
    output logic signed [iirdf1_pkg::SAMP_W-1:0]    x_out,
    output logic signed [iirdf1_pkg::SAMP_W-1:0]    y_out,
    output logic signed [iirdf1_pkg::ACC_W-1:0]     acc_out
);
    import iirdf1_pkg::*;

    logic signed [SAMP_W-1:0] x_reg;
    logic signed [SAMP_W-1:0] x_next;
    logic signed [SAMP_W-1:0] y_reg;
    logic signed [SAMP_W-1:0] y_next;
    logic signed [PROD_W-1:0] ff_prod;
    logic signed [PROD_W-1:0] fb_prod;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (clear)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (advance)
        begin
            x_next = x_in;
            y_next = y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign ff_prod = PROD_W'(x_reg) * PROD_W'(ff_coef);
    assign fb_prod = PROD_W'(y_reg) * PROD_W'(fb_coef);
    assign acc_out = acc_in + ACC_W'(ff_prod) + ACC_W'(fb_prod);
    assign x_out   = x_reg;
    assign y_out   = y_reg;

endmodule

[hdl/iirdf1_rndsat.sv]
`timescale 1ns / 1ps
// ============================================================================
// iirdf1_rndsat
// Rounds the Q7.29 sum to Q1.15 (half toward plus infinity) and saturates.
// ============================================================================
module iirdf1_rndsat (
    input  logic signed [iirdf1_pkg::ACC_W-1:0] acc,
    output iirdf1_pkg::flt_t                    flt
);
    import iirdf1_pkg::*;

    localparam int Q_W = ACC_W + 1 - FRAC_SHIFT;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAMP_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SAMP_MIN);

    logic signed [ACC_W:0] biased;
    logic signed [Q_W-1:0] q;

    assign biased = (ACC_W+1)'(acc) + (ACC_W+1)'(ROUND_HALF);
    assign q      = $signed(biased[ACC_W:FRAC_SHIFT]);

    always_comb
    begin
        priority if (q > Q_MAX)
        begin
            flt.filtered = SAMP_MAX;
            flt.clipped  = 1'b1;
        end
        else if (q < Q_MIN)
        begin
            flt.filtered = SAMP_MIN;
            flt.clipped  = 1'b1;
        end
        else
        begin
            flt.filtered = q[SAMP_W-1:0];
            flt.clipped  = 1'b0;
        end
    end

endmodule

[sim/iir_filter_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// iir_filter_checker
// Predicts and checks the output beats of the direct form I IIR filter.
// ============================================================================
// Follows the APB coefficient writes and the accepted sample beats, keeps its
// own copy of both delay lines, and computes the rounded and saturated output
// of every filter beat. Each accepted output beat is compared field by field
// with the oldest prediction.
module iir_filter_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           smp_valid,
    input  logic                           smp_ready,
    input  iirdf1_pkg::smp_t               smp,
    input  logic                           flt_valid,
    input  logic                           flt_ready,
    input  iirdf1_pkg::flt_t               flt,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [iirdf1_pkg::PADDR_W-1:0] paddr,
    input  logic [iirdf1_pkg::PDATA_W-1:0] pwdata,
    output int                             mismatches,
    output int                             outstanding
);

    import iirdf1_pkg::*;

    logic signed [COEF_W-1:0] ff_w [FF_TAPS];
    logic signed [COEF_W-1:0] fb_w [FB_TAPS];
    logic signed [SAMP_W-1:0] x_hist [NUM_CELLS];
    logic signed [SAMP_W-1:0] y_hist [NUM_CELLS];

    flt_t expected_out [$];
    flt_t want;
    int   reg_idx;

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // one filter beat: exact Q35.29 sum, round half up, saturate, shift histories
    function automatic flt_t filter_sample(input logic signed [SAMP_W-1:0] x_now);
        longint                   acc;
        longint                   y;
        logic signed [SAMP_W-1:0] tap;
        flt_t                     r;
        int                       k;
        acc = 0;
        if (FF_TAPS < 1)
            acc = longint'(x_now) <<< FRAC_SHIFT;
        else
            for (k = 0; k < FF_TAPS; k++)
            begin
                tap = (k == 0) ? x_now : x_hist[k-1];
                acc += longint'(tap) * longint'(ff_w[k]);
            end
        for (k = 0; k < FB_TAPS; k++)
        begin
            tap = (k == 0) ? y_hist[0] : y_hist[k-1];
            acc += longint'(tap) * longint'(fb_w[k]);
        end
        y = (acc + ROUND_HALF) >>> FRAC_SHIFT;
        r.clipped = 1'b0;
        if (y > longint'(SAMP_MAX))
        begin
            y = longint'(SAMP_MAX);
            r.clipped = 1'b1;
        end
        else if (y < longint'(SAMP_MIN))
        begin
            y = longint'(SAMP_MIN);
            r.clipped = 1'b1;
        end
        r.filtered = y[SAMP_W-1:0];
        for (k = NUM_CELLS - 1; k > 0; k--)
        begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x_now;
        y_hist[0] = r.filtered;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FF_TAPS; k++)
                ff_w[k] = '0;
            for (int k = 0; k < FB_TAPS; k++)
                fb_w[k] = '0;
            for (int k = 0; k < NUM_CELLS; k++)
            begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
            expected_out.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = int'(paddr[PADDR_W-1:2]);
                if (reg_idx < FF_TAPS)
                    ff_w[reg_idx] = pwdata[COEF_W-1:0];
                else if (reg_idx < NUM_REGS)
                    fb_w[reg_idx - FF_TAPS] = pwdata[COEF_W-1:0];
            end
            if (flt_valid && flt_ready)
            begin
                if (expected_out.size() == 0)
                    report_mismatch($sformatf("output beat %0d/%0b with none expected",
                                              flt.filtered, flt.clipped));
                else
                begin
                    want = expected_out.pop_front();
                    if (flt.filtered !== want.filtered)
                        report_mismatch($sformatf("filtered %0d, expected %0d",
                                                  flt.filtered, want.filtered));
                    if (flt.clipped !== want.clipped)
                        report_mismatch($sformatf("clipped %0b, expected %0b",
                                                  flt.clipped, want.clipped));
                end
            end
            if (smp_valid && smp_ready)
            begin
                if (smp.op == OP_CLEAR)
                    for (int k = 0; k < NUM_CELLS; k++)
                    begin
                        x_hist[k] = '0;
                        y_hist[k] = '0;
                    end
                else
                    expected_out.push_back(filter_sample(smp.sample));
            end
            outstanding <= expected_out.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus and verdict for the direct form I IIR filter.
// ============================================================================
// Loads coefficient sets over APB while the filter is idle, then streams
// sample and clear beats: a directed pass over the field extremes, rounding
// ties and saturation, followed by random phases with varied coefficient
// mixes. Both channels stall in random bursts but not in phase 4 or at the end.
// The checker beside the filter predicts and compares every output beat.
module testbench;

    import iirdf1_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 110;
    localparam int REG_FF_BASE = 0;
    localparam int REG_FB_BASE = FF_TAPS;

    typedef enum int {CF_FULL, CF_MILD, CF_MAX, CF_MIN, CF_FIR} coef_mix_e;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               smp_valid = 1'b0;
    logic               smp_ready;
    smp_t               smp       = '0;
    logic               flt_valid;
    logic               flt_ready = 1'b0;
    flt_t               flt;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 mismatches;
    int                 outstanding;
    int                 quiet_cycles = 0;
    int                 stall_left   = 0;
    bit                 idle_en      = 1'b1;

    logic signed [COEF_W-1:0] coef_ff [FF_TAPS];
    logic signed [COEF_W-1:0] coef_fb [FB_TAPS];

    always #5 clk = ~clk;

    iir_direct_form_one_filter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp       (smp),
        .flt_valid (flt_valid),
        .flt_ready (flt_ready),
        .flt       (flt),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    iir_filter_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .smp_valid   (smp_valid),
        .smp_ready   (smp_ready),
        .smp         (smp),
        .flt_valid   (flt_valid),
        .flt_ready   (flt_ready),
        .flt         (flt),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            flt_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            flt_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
            flt_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((smp_valid && smp_ready) || (flt_valid && flt_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input logic op, input logic signed [SAMP_W-1:0] s);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            smp_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        smp_valid <= 1'b1;
        smp       <= {op, s};
        @(posedge clk);
        while (!smp_ready)
            @(posedge clk);
    endtask

    task automatic reg_write(input int idx, input logic signed [COEF_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx << 2);
        pwdata  <= {{(PDATA_W-COEF_W){v[COEF_W-1]}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // drain the filter, then write the whole coefficient set
    task automatic load_coefs();
        smp_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        for (int k = 0; k < FF_TAPS; k++)
            reg_write(REG_FF_BASE + k, coef_ff[k]);
        for (int k = 0; k < FB_TAPS; k++)
            reg_write(REG_FB_BASE + k, coef_fb[k]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_coefs(input logic signed [COEF_W-1:0] ffv,
                             input logic signed [COEF_W-1:0] fbv);
        for (int k = 0; k < FF_TAPS; k++)
            coef_ff[k] = ffv;
        for (int k = 0; k < FB_TAPS; k++)
            coef_fb[k] = fbv;
    endtask

    function automatic logic signed [SAMP_W-1:0] pick_sample();
        logic signed [SAMP_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = SAMP_MAX;
            1:       v = SAMP_MIN;
            2:       v = SAMP_W'($urandom_range(0, 2) - 1);
            3, 4, 5: v = SAMP_W'($urandom_range(0, 8191) - 4096);
            default: v = SAMP_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef(input coef_mix_e mix,
                                                           input bit feedback);
        logic signed [COEF_W-1:0] v;
        case (mix)
            CF_MAX:  v = SAMP_MAX;
            CF_MIN:  v = SAMP_MIN;
            CF_MILD: v = feedback ? COEF_W'($urandom_range(0, 8191) - 4096)
                                  : COEF_W'($urandom_range(0, 16383) - 8192);
            CF_FIR:  v = feedback ? '0 : COEF_W'($urandom_range(0, 65535));
            default: v = COEF_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    initial
    begin
        coef_mix_e mix;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: all zero output
        send_beat(OP_FILTER, SAMP_MAX);

        // unity gain: extremes and bit patterns pass through
        set_coefs('0, '0);
        coef_ff[0] = 16'sd16384;
        load_coefs();
        send_beat(OP_FILTER, SAMP_MAX);
        send_beat(OP_FILTER, SAMP_MIN);
        send_beat(OP_FILTER, 16'sd0);
        send_beat(OP_FILTER, 16'sd1);
        send_beat(OP_FILTER, -16'sd1);
        send_beat(OP_FILTER, 16'h5555);
        send_beat(OP_FILTER, 16'hAAAA);
        send_beat(OP_CLEAR, SAMP_MAX);

        // rounding ties go toward plus infinity
        set_coefs('0, '0);
        coef_ff[0] = 16'sd1;
        load_coefs();
        send_beat(OP_FILTER, 16'sd8192);
        send_beat(OP_FILTER, -16'sd8192);
        send_beat(OP_FILTER, 16'sd8191);
        send_beat(OP_FILTER, -16'sd8193);

        // saturation both ways, clear in the middle of a history
        set_coefs(SAMP_MAX, SAMP_MAX);
        load_coefs();
        send_beat(OP_FILTER, SAMP_MAX);
        send_beat(OP_FILTER, SAMP_MAX);
        send_beat(OP_CLEAR, 16'sd0);
        send_beat(OP_FILTER, SAMP_MIN);
        send_beat(OP_FILTER, SAMP_MIN);

        set_coefs(SAMP_MIN, SAMP_MIN);
        load_coefs();
        send_beat(OP_FILTER, SAMP_MIN);
        send_beat(OP_FILTER, SAMP_MAX);
        send_beat(OP_FILTER, 16'sd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_en = (ph < PHASES - 2) && (ph != 4);
            mix     = coef_mix_e'(ph % 5);
            for (int k = 0; k < FF_TAPS; k++)
                coef_ff[k] = pick_coef(mix, 1'b0);
            for (int k = 0; k < FB_TAPS; k++)
                coef_fb[k] = pick_coef(mix, 1'b1);
            load_coefs();
            for (int n = 0; n < PHASE_BEATS; n++)
                send_beat(($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_FILTER,
                          pick_sample());
        end

        smp_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hdl/iirdf1_pkg.sv
hdl/iirdf1_cell.sv
hdl/iirdf1_rndsat.sv
hdl/iir_direct_form_one_filter_top.sv
sim/iir_filter_checker.sv
sim/testbench.sv
